@@ hdl/fldm_pkg.sv @@
// ----------------------------------------------------------------------------
// fldm_pkg
// shared types and constants of the fuel level drop monitor
// ----------------------------------------------------------------------------
`default_nettype none

package fldm_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);

    localparam int ADC_W    = 12;
    localparam int LEVEL_W  = 20;
    localparam int LIMIT_W  = 21;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;

    // level = adc * 1000000 / 4095 = adc * SCALE_WHOLE + adc * SCALE_FRAC / 4095
    localparam int ADC_FULL    = 4095;
    localparam int SCALE_WHOLE = 1000000 / ADC_FULL;
    localparam int SCALE_FRAC  = 1000000 % ADC_FULL;
    localparam int FRAC_W      = 22;

    localparam logic [COUNT_W-1:0] DROPS_FOR_THEFT = 2'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CHECK  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ALARM  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LIMIT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_RUNNING  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_STOPPED  = 2'd3;

    localparam logic [LEVEL_W-1:0]        LOW_LIMIT_RST    = 20'd200000;
    localparam logic [LEVEL_W-1:0]        HIGH_LIMIT_RST   = 20'd950000;
    localparam logic signed [LIMIT_W-1:0] DROP_RUNNING_RST = -21'sd50000;
    localparam logic signed [LIMIT_W-1:0] DROP_STOPPED_RST = -21'sd30000;

    typedef struct packed {
        logic                window_ready;
        logic                theft_raised;
        logic [STATUS_W-1:0] theft_status;
        logic [STATUS_W-1:0] high_alarm;
        logic [STATUS_W-1:0] low_alarm;
        logic [LEVEL_W-1:0]  level;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // exact floor(adc * 1000000 / 4095) with shift-add constant products
    function automatic logic [LEVEL_W-1:0] scale_level(input logic [ADC_W-1:0] adc);
        logic [LEVEL_W-1:0] whole;
        logic [FRAC_W-1:0]  frac_prod;
        logic [9:0]         q_est;
        logic [ADC_W:0]     rem;
        logic [LEVEL_W-1:0] frac;
        whole     = LEVEL_W'(adc * SCALE_WHOLE);
        frac_prod = FRAC_W'(adc * SCALE_FRAC);
        q_est     = frac_prod[FRAC_W-1:ADC_W];
        rem       = {1'b0, frac_prod[ADC_W-1:0]} + (ADC_W+1)'(q_est);
        frac      = LEVEL_W'(q_est) + ((rem >= (ADC_W+1)'(ADC_FULL)) ? 20'd1 : 20'd0);
        return whole + frac;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fuel_level_drop_monitor_top.sv @@
// ----------------------------------------------------------------------------
// fuel_level_drop_monitor_top
// fuel level scaling, level alarms and sliding-window drop detection
// ----------------------------------------------------------------------------
// Every accepted input word gives exactly one result word. A word goes from an
// input register through the scaling, alarm and window logic into the result
// register; the input register holds it while the result register is stalled.
// One word per cycle is sustained while m_tready stays high; the result register
// decouples the two sides, so one new word can be taken into the input register
// while a result waits.
// The configuration channel is always ready and should only be written while
// no words are in flight.
`default_nettype none

module fuel_level_drop_monitor_top
(
    input  wire                               clk,
    input  wire                               rst_n,

    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [fldm_pkg::S_TDATA_W-1:0]    s_tdata,   // adc_value, generator_running
    input  wire                               s_tuser,   // func

    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [fldm_pkg::M_TDATA_W-1:0]    m_tdata,   // level, low_alarm, high_alarm,
                                                         // theft_status, theft_raised,
                                                         // window_ready

    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [fldm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [fldm_pkg::LIMIT_W-1:0]      cfg_data
);

    import fldm_pkg::*;

    logic                       in_vld_reg;
    logic                       in_func_reg;
    logic [ADC_W-1:0]           in_adc_reg;
    logic                       in_gen_reg;

    logic                       out_vld_reg, out_vld_next;
    result_t                    out_reg, out_next;

    logic [LEVEL_W-1:0]         low_limit_reg;
    logic [LEVEL_W-1:0]         high_limit_reg;
    logic signed [LIMIT_W-1:0]  drop_running_reg;
    logic signed [LIMIT_W-1:0]  drop_stopped_reg;

    logic [LEVEL_W-1:0]         win_reg [WINDOW_DEPTH];
    logic [LEVEL_W-1:0]         win_next [WINDOW_DEPTH];
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic                       full_reg, full_next;
    logic [COUNT_W-1:0]         drops_reg, drops_next;
    logic [LEVEL_W-1:0]         level_reg, level_next;
    logic [STATUS_W-1:0]        low_reg, low_next;
    logic [STATUS_W-1:0]        high_reg, high_next;
    logic [STATUS_W-1:0]        theft_reg, theft_next;

    logic                       advance;
    logic                       in_take;
    logic [LEVEL_W-1:0]         new_level;
    logic signed [LIMIT_W-1:0]  delta;
    logic signed [LIMIT_W-1:0]  limit;
    logic [COUNT_W-1:0]         drops_inc;
    logic                       raised;

    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {(M_TDATA_W-RESULT_W)'(0), out_reg};
    assign cfg_ready = 1'b1;

    assign new_level = scale_level(in_adc_reg);
    assign delta     = $signed({1'b0, win_reg[WINDOW_DEPTH-1]}) - $signed({1'b0, win_reg[0]});
    assign limit     = in_gen_reg ? drop_running_reg : drop_stopped_reg;
    assign drops_inc = drops_reg + 2'd1;

    always_comb
    begin
        win_next   = win_reg;
        slot_next  = slot_reg;
        full_next  = full_reg;
        drops_next = drops_reg;
        level_next = level_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        theft_next = theft_reg;
        raised     = 1'b0;
        if (advance)
        begin
            if (in_func_reg == FUNC_SAMPLE)
            begin
                win_next[slot_reg] = new_level;
                level_next = new_level;
                low_next   = (new_level < low_limit_reg)  ? STATUS_ALARM : STATUS_NORMAL;
                high_next  = (new_level > high_limit_reg) ? STATUS_ALARM : STATUS_NORMAL;
                if (slot_reg < SLOT_W'(WINDOW_DEPTH-1))
                begin
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    full_next = 1'b1;
                end
            end
            else if (full_reg)
            begin
                for (int k = 0; k < WINDOW_DEPTH-1; k++)
                begin
                    win_next[k] = win_reg[k+1];
                end
                if (delta < limit)
                begin
                    if (drops_inc == DROPS_FOR_THEFT)
                    begin
                        drops_next = '0;
                        theft_next = STATUS_ALARM;
                        raised     = 1'b1;
                    end
                    else
                    begin
                        drops_next = drops_inc;
                    end
                end
                else
                begin
                    theft_next = STATUS_NORMAL;
                end
            end
        end
    end

    always_comb
    begin
        out_next.level        = level_next;
        out_next.low_alarm    = low_next;
        out_next.high_alarm   = high_next;
        out_next.theft_status = theft_next;
        out_next.theft_raised = raised;
        out_next.window_ready = full_next;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            slot_reg    <= '0;
            full_reg    <= 1'b0;
            drops_reg   <= '0;
            level_reg   <= '0;
            low_reg     <= STATUS_NONE;
            high_reg    <= STATUS_NONE;
            theft_reg   <= STATUS_NONE;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            out_vld_reg <= out_vld_next;
            slot_reg    <= slot_next;
            full_reg    <= full_next;
            drops_reg   <= drops_next;
            level_reg   <= level_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            theft_reg   <= theft_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg    <= LOW_LIMIT_RST;
            high_limit_reg   <= HIGH_LIMIT_RST;
            drop_running_reg <= DROP_RUNNING_RST;
            drop_stopped_reg <= DROP_STOPPED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_LIMIT:    low_limit_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_HIGH_LIMIT:   high_limit_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_DROP_RUNNING: drop_running_reg <= $signed(cfg_data);
                CFG_DROP_STOPPED: drop_stopped_reg <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg <= s_tuser;
            in_adc_reg  <= s_tdata[ADC_W-1:0];
            in_gen_reg  <= s_tdata[ADC_W];
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

@@ hdl/fldm_checker.sv @@
// ----------------------------------------------------------------------------
// fldm_checker
// port-level checks of the fuel level drop monitor
// ----------------------------------------------------------------------------
`default_nettype none

module fldm_checker
(
    input wire                               clk,
    input wire                               rst_n,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [fldm_pkg::M_TDATA_W-1:0]     m_tdata
);

    import fldm_pkg::*;

    result_t res;
    assign res = m_tdata[RESULT_W-1:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_raise_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.theft_raised |-> res.theft_status == STATUS_ALARM)
        else $error("theft raised without theft status");

    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && res.window_ready |=> !m_tvalid || res.window_ready)
        else $error("window ready dropped");

    a_level_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.level != '0 |-> res.low_alarm != STATUS_NONE
                                        && res.high_alarm != STATUS_NONE)
        else $error("level without evaluated alarms");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:RESULT_W] == '0)
        else $error("padding bits set");

endmodule

bind fuel_level_drop_monitor_top fldm_checker u_fldm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
